// ----- hdl/fcgirr_pkg.sv -----
package fcgirr_pkg;

    // request codes on the slave-side tuser
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // result kinds on the master-side tuser
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // deframer phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_CONTENT = 2'd1;
    localparam logic [1:0] PH_PADDING = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    // record types
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;
    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;

    localparam int unsigned HDR_BYTES = 8;
    localparam logic [2:0]  HDR_LAST  = 3'd7;

    // configuration registers
    localparam logic       CFG_MAX_TOTAL  = 1'b0;
    localparam logic       CFG_MAX_RECORD = 1'b1;
    localparam int unsigned CNT_W = 27;
    localparam int unsigned TALLY_W = 17;
    localparam logic [CNT_W-1:0]   MAX_TOTAL_RST  = 27'd67108864;
    localparam logic [TALLY_W-1:0] MAX_RECORD_RST = 17'd100000;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] data;
    } t_result;

endpackage

// ----- hdl/fcgirr_in_reg.sv -----
module fcgirr_in_reg
    import fcgirr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // stage is free when empty or drained this cycle
    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hdl/fcgirr_deframe.sv -----
module fcgirr_deframe
    import fcgirr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_step,
    input  t_item              i_item,
    output t_result            o_result
);

    logic [CNT_W-1:0]   r_max_total;
    logic [TALLY_W-1:0] r_max_record;

    logic [1:0]         r_phase,   n_phase;
    logic [2:0]         r_pos,     n_pos;
    logic [7:0]         r_type,    n_type;
    logic [15:0]        r_content, n_content;
    logic [7:0]         r_pad,     n_pad;
    logic [CNT_W-1:0]   r_total,   n_total;
    logic [CNT_W-1:0]   r_stdout,  n_stdout;
    logic [TALLY_W-1:0] r_tally,   n_tally;
    logic               r_skip,    n_skip;

    t_result            res;
    logic               do_complete;
    logic               do_fail;
    logic [15:0]        content_dec;
    logic [7:0]         pad_dec;
    logic [17:0]        rec_len;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_total  <= MAX_TOTAL_RST;
            r_max_record <= MAX_RECORD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_TOTAL:  r_max_total  <= i_cfg_data;
                CFG_MAX_RECORD: r_max_record <= i_cfg_data[TALLY_W-1:0];
                default: ;
            endcase
        end
    end

    assign content_dec = (r_content != 16'd0) ? r_content - 16'd1 : 16'd0;
    assign pad_dec     = (r_pad != 8'd0) ? r_pad - 8'd1 : 8'd0;
    assign rec_len     = 18'(HDR_BYTES) + {2'b00, r_content} + {10'd0, r_pad};

    // one request step of deframing (data byte, close or start)
    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_type      = r_type;
        n_content   = r_content;
        n_pad       = r_pad;
        n_total     = r_total;
        n_stdout    = r_stdout;
        n_tally     = r_tally;
        n_skip      = r_skip;
        res         = '0;
        do_complete = 1'b0;
        do_fail     = 1'b0;

        if (i_item.op == OP_START) begin
            n_phase   = PH_HEADER;
            n_pos     = 3'd0;
            n_type    = 8'd0;
            n_content = 16'd0;
            n_pad     = 8'd0;
            n_total   = '0;
            n_stdout  = '0;
            n_tally   = '0;
            n_skip    = 1'b0;
        end else if (i_item.op == OP_CLOSE && r_phase != PH_STOPPED) begin
            do_fail = 1'b1;
        end else if (i_item.op == OP_DATA && r_phase != PH_STOPPED) begin
            if (r_total >= r_max_total) begin
                do_fail = 1'b1;
            end else begin
                n_total = r_total + 1'b1;
                case (r_phase)
                    PH_HEADER: begin
                        case (r_pos)
                            3'd1: n_type = i_item.data;
                            3'd4: n_content = {i_item.data, r_content[7:0]};
                            3'd5: n_content = {r_content[15:8], i_item.data};
                            3'd6: n_pad = i_item.data;
                            default: ;
                        endcase
                        if (r_pos == HDR_LAST) begin
                            // header done: nothing was loaded this byte
                            n_pos = 3'd0;
                            if (r_type == TYPE_STDOUT && r_content == 16'd0) begin
                                // empty stdout record: uncounted, padding skipped
                                if (r_pad == 8'd0) begin
                                    n_phase = PH_HEADER;
                                end else begin
                                    n_skip  = 1'b1;
                                    n_phase = PH_PADDING;
                                end
                            end else if ({9'd0, rec_len} > r_max_total) begin
                                do_fail = 1'b1;
                            end else if (r_content != 16'd0) begin
                                n_phase = PH_CONTENT;
                            end else if (r_pad != 8'd0) begin
                                n_phase = PH_PADDING;
                            end else begin
                                do_complete = 1'b1;
                            end
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end
                    PH_CONTENT: begin
                        if (r_type == TYPE_STDOUT && r_stdout >= r_max_total) begin
                            do_fail = 1'b1;
                        end else begin
                            if (r_type == TYPE_STDOUT) begin
                                n_stdout = r_stdout + 1'b1;
                                res = '{valid: 1'b1, kind: KIND_BYTE, data: i_item.data};
                            end
                            n_content = content_dec;
                            if (content_dec == 16'd0) begin
                                if (r_pad != 8'd0) begin
                                    n_phase = PH_PADDING;
                                end else begin
                                    do_complete = 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        n_pad = pad_dec;
                        if (pad_dec == 8'd0) begin
                            if (r_skip) begin
                                n_skip  = 1'b0;
                                n_phase = PH_HEADER;
                            end else begin
                                do_complete = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        // record completion: count it, or fail at the record limit; an end-request record reports end of request
        if (do_complete) begin
            if (r_tally >= r_max_record) begin
                do_fail = 1'b1;
            end else begin
                n_tally = r_tally + 1'b1;
                if (r_type == TYPE_END_REQUEST) begin
                    n_phase = PH_STOPPED;
                    res = '{valid: 1'b1, kind: KIND_END, data: 8'd0};
                end else begin
                    n_phase = PH_HEADER;
                end
            end
        end

        // error replaces any other result and stops the block
        if (do_fail) begin
            n_phase = PH_STOPPED;
            res = '{valid: 1'b1, kind: KIND_ERROR, data: 8'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pos     <= 3'd0;
            r_type    <= 8'd0;
            r_content <= 16'd0;
            r_pad     <= 8'd0;
            r_total   <= '0;
            r_stdout  <= '0;
            r_tally   <= '0;
            r_skip    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_content <= n_content;
            r_pad     <= n_pad;
            r_total   <= n_total;
            r_stdout  <= n_stdout;
            r_tally   <= n_tally;
            r_skip    <= n_skip;
        end
    end

    assign o_result = res;

endmodule

// ----- hdl/fcgirr_out_reg.sv -----
module fcgirr_out_reg
    import fcgirr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_data
);

    logic       r_valid;
    logic [1:0] r_kind;
    logic [7:0] r_data;

    // load only when empty or the held result is being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_result.valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_result.valid) begin
            r_kind <= i_result.kind;
            r_data <= i_result.data;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_data  = r_data;

endmodule

// ----- hdl/fastcgi_record_receiver_core.sv -----
// FastCGI upstream record deframer.
// Slave-side stream: one upstream request per beat; tdata is the byte,
// tuser the request code (data byte, upstream closed, start new request).
// Master-side stream: at most one result per request; tuser gives the
// kind (stdout payload byte, end of request, upstream error), tdata the
// payload byte or zero.
// Configuration: i_cfg_we with i_cfg_idx 0 writes max_total_bytes, index 1
// writes max_record_count; write only while no request is in flight.
// An accepted request is held in the input register, and its result is
// loaded into the result register (input register, then result register).
// Throughput: one request per cycle unless the master side stalls; the whole
// record step is one pass of logic between the input and result registers.
// Reset clears the deframer state and loads the default limits; both
// streams come up empty. When the master side stalls, the result register
// holds, the input register fills, and s_axis_tready drops until the
// pending result is taken.
module fastcgi_record_receiver_core
    import fcgirr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [26:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser    // [1:0] out_kind
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    step;
    t_result step_result;

    assign in_item = '{op: s_axis_tuser, data: s_axis_tdata};

    // a held request is processed when the result register can take it
    assign step = held_valid && (!m_axis_tvalid || m_axis_tready);

    fcgirr_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    fcgirr_deframe u_deframe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_item     (held_item),
        .o_result   (step_result)
    );

    fcgirr_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_kind   (m_axis_tuser),
        .o_data   (m_axis_tdata)
    );

endmodule

// ----- hdl/fcgirr_checker.sv -----
module fcgirr_checker
    import fcgirr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // only the three defined result kinds appear
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_BYTE || m_axis_tuser == KIND_END ||
             m_axis_tuser == KIND_ERROR))
        else $error("undefined result kind");

    // end and error results carry a zero byte
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_BYTE |-> m_axis_tdata == 8'd0)
        else $error("nonzero byte on status result");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind fastcgi_record_receiver_core fcgirr_checker u_fcgirr_checker (.*);
